// ===== sv/per_flow_seq_regression_counter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the per-flow sequence regression counter
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PER_FLOW_SEQ_REGRESSION_COUNTER_ASSERT_SVH
`define PER_FLOW_SEQ_REGRESSION_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define PFSRC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define PFSRC_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// ===== sv/pfsrc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfsrc_pkg
// Shared constants for the per-flow sequence regression counter.
// ----------------------------------------------------------------------------
package pfsrc_pkg;

    localparam int          FLOW_ENTRIES_DEF = 64;
    localparam int          LATENCY          = 3;
    localparam logic [7:0]  TCP_PROTO        = 8'd6;
    localparam logic [31:0] COUNT_MAX        = 32'hFFFF_FFFF;

endpackage

// ===== sv/per_flow_seq_regression_counter.sv =====
// ----------------------------------------------------------------------------
// per_flow_seq_regression_counter
// Flow table with a parallel key compare; counts TCP sequence decreases per
// flow and reports the count for every packet transaction.
// ----------------------------------------------------------------------------
// Channel   Handshake        Direction  Payload
// command   start / busy     in         src_addr dst_addr src_port dst_port
//                                       protocol seq_number
// result    done (strobe)    out        regressions new_flow table_full ignored
//
// One transaction may be started every cycle; busy is always low.
// done is high for one cycle; a start is registered through s1_vld_reg, s2_vld_reg and done_reg.
// Lookup and allocation happen in the key stage; the per-flow sequence and
// count live in a RAM with registered read, written back in the update stage.
// Reset clears the valid bits and the free pointer at once; no clear pass.
// The receiver cannot stall; the pipeline never holds.
// ----------------------------------------------------------------------------
module per_flow_seq_regression_counter #(
    parameter int FLOW_ENTRIES = pfsrc_pkg::FLOW_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    input  logic [7:0]  protocol,
    input  logic [31:0] seq_number,
    output logic        done,
    output logic [31:0] regressions,
    output logic        new_flow,
    output logic        table_full,
    output logic        ignored
);

    localparam int IDX_W = $clog2(FLOW_ENTRIES);
    localparam int CNT_W = $clog2(FLOW_ENTRIES + 1);

    localparam logic [1:0] KIND_IGNORE = 2'd0;
    localparam logic [1:0] KIND_HIT    = 2'd1;
    localparam logic [1:0] KIND_NEW    = 2'd2;
    localparam logic [1:0] KIND_FULL   = 2'd3;

    // key stage
    logic        s1_vld_reg;
    logic        s1_tcp_reg;
    logic [63:0] s1_addrs_reg;
    logic [31:0] s1_ports_reg;
    logic [31:0] s1_seq_reg;

    // flow keys
    logic [FLOW_ENTRIES-1:0] key_valid_reg;
    logic [63:0]             key_addrs_reg [FLOW_ENTRIES];
    logic [31:0]             key_ports_reg [FLOW_ENTRIES];
    logic [CNT_W-1:0]        next_free_reg;
    logic [CNT_W-1:0]        next_free_next;

    logic [FLOW_ENTRIES-1:0] hit_vec;
    logic                    s1_hit;
    logic [IDX_W-1:0]        s1_hit_idx;
    logic [IDX_W-1:0]        s1_idx;
    logic                    s1_full;
    logic                    s1_alloc;
    logic [1:0]              s1_kind;

    // update stage
    logic             s2_vld_reg;
    logic [1:0]       s2_kind_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [31:0]      s2_seq_reg;
    logic             s2_fwd_reg;
    logic             s2_fwd_next;
    logic [63:0]      rd_data_reg;
    logic [63:0]      wr_data_reg;

    logic [63:0]      flow_mem [FLOW_ENTRIES];

    logic [63:0] s2_cur;
    logic        s2_bump;
    logic [31:0] s2_new_cnt;
    logic        s2_wr;
    logic [63:0] s2_wdata;
    logic [31:0] s2_res_cnt;
    logic        s2_new;
    logic        s2_full;
    logic        s2_ign;

    // result register
    logic        done_reg;
    logic [31:0] regressions_reg;
    logic        new_flow_reg;
    logic        table_full_reg;
    logic        ignored_reg;

    assign busy = 1'b0;

    always_comb
    begin
        hit_vec    = '0;
        s1_hit_idx = '0;
        for (int i = 0; i < FLOW_ENTRIES; i++)
        begin
            hit_vec[i] = key_valid_reg[i] && (key_addrs_reg[i] == s1_addrs_reg)
                         && (key_ports_reg[i] == s1_ports_reg);
            if (hit_vec[i])
            begin
                s1_hit_idx = s1_hit_idx | IDX_W'(i);
            end
        end
    end

    assign s1_hit   = |hit_vec;
    assign s1_full  = (next_free_reg == CNT_W'(FLOW_ENTRIES));
    assign s1_alloc = s1_vld_reg && s1_tcp_reg && !s1_hit && !s1_full;
    assign s1_idx   = s1_hit ? s1_hit_idx : next_free_reg[IDX_W-1:0];
    assign next_free_next = s1_alloc ? next_free_reg + CNT_W'(1) : next_free_reg;

    always_comb
    begin
        if (!s1_tcp_reg)
        begin
            s1_kind = KIND_IGNORE;
        end
        else if (s1_hit)
        begin
            s1_kind = KIND_HIT;
        end
        else if (s1_full)
        begin
            s1_kind = KIND_FULL;
        end
        else
        begin
            s1_kind = KIND_NEW;
        end
    end

    // previous write lands on the entry now being read
    assign s2_fwd_next = s2_wr && (s2_idx_reg == s1_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            done_reg      <= 1'b0;
            key_valid_reg <= '0;
            next_free_reg <= '0;
        end
        else
        begin
            s1_vld_reg    <= start && !busy;
            s2_vld_reg    <= s1_vld_reg;
            done_reg      <= s2_vld_reg;
            next_free_reg <= next_free_next;
            if (s1_alloc)
            begin
                key_valid_reg[next_free_reg[IDX_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_tcp_reg   <= (protocol == pfsrc_pkg::TCP_PROTO);
        s1_addrs_reg <= {src_addr, dst_addr};
        s1_ports_reg <= {src_port, dst_port};
        s1_seq_reg   <= seq_number;
        if (s1_alloc)
        begin
            key_addrs_reg[next_free_reg[IDX_W-1:0]] <= s1_addrs_reg;
            key_ports_reg[next_free_reg[IDX_W-1:0]] <= s1_ports_reg;
        end
        s2_kind_reg <= s1_kind;
        s2_idx_reg  <= s1_idx;
        s2_seq_reg  <= s1_seq_reg;
        s2_fwd_reg  <= s2_fwd_next;
        if (s2_wr)
        begin
            wr_data_reg <= s2_wdata;
        end
        regressions_reg <= s2_res_cnt;
        new_flow_reg    <= s2_new;
        table_full_reg  <= s2_full;
        ignored_reg     <= s2_ign;
    end

    // sequence in [63:32], count in [31:0]
    always_ff @(posedge clk)
    begin
        if (s2_wr)
        begin
            flow_mem[s2_idx_reg] <= s2_wdata;
        end
        rd_data_reg <= flow_mem[s1_idx];
    end

    assign s2_cur     = s2_fwd_reg ? wr_data_reg : rd_data_reg;
    assign s2_bump    = (s2_cur[63:32] > s2_seq_reg) && (s2_cur[31:0] != pfsrc_pkg::COUNT_MAX);
    assign s2_new_cnt = s2_cur[31:0] + 32'(s2_bump);

    always_comb
    begin
        s2_wr      = 1'b0;
        s2_wdata   = {s2_seq_reg, 32'd0};
        s2_res_cnt = 32'd0;
        s2_new     = 1'b0;
        s2_full    = 1'b0;
        s2_ign     = 1'b0;
        case (s2_kind_reg)
            KIND_HIT:
            begin
                s2_wr      = s2_vld_reg;
                s2_wdata   = {s2_seq_reg, s2_new_cnt};
                s2_res_cnt = s2_new_cnt;
            end
            KIND_NEW:
            begin
                s2_wr  = s2_vld_reg;
                s2_new = 1'b1;
            end
            KIND_FULL:
            begin
                s2_full = 1'b1;
            end
            KIND_IGNORE:
            begin
                s2_ign = 1'b1;
            end
            default:
            begin
                s2_ign = 1'b1;
            end
        endcase
    end

    assign done        = done_reg;
    assign regressions = regressions_reg;
    assign new_flow    = new_flow_reg;
    assign table_full  = table_full_reg;
    assign ignored     = ignored_reg;

endmodule

// ===== sv/pfsrc_checker.sv =====
// ----------------------------------------------------------------------------
// pfsrc_checker
// Port-level checks for the per-flow sequence regression counter.
// ----------------------------------------------------------------------------
`include "per_flow_seq_regression_counter_assert.svh"

module pfsrc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [7:0]  protocol,
    input logic        done,
    input logic [31:0] regressions,
    input logic        new_flow,
    input logic        table_full,
    input logic        ignored
);

    `PFSRC_ASSERT_DLY(a_start_done, start && !busy, 3, done, "transaction gave no result")
    `PFSRC_ASSERT_IMP(a_done_start, done, $past(start && !busy, pfsrc_pkg::LATENCY), "result without transaction")
    `PFSRC_ASSERT_IMP(a_flags, done, $onehot0({new_flow, table_full, ignored}), "conflicting result flags")
    `PFSRC_ASSERT_IMP(a_zero_cnt, done && (new_flow || table_full || ignored), regressions == 32'd0, "count on flagged result")
    `PFSRC_ASSERT_IMP(a_ignored, done, ignored == ($past(protocol, pfsrc_pkg::LATENCY) != pfsrc_pkg::TCP_PROTO), "ignored flag mismatch")

endmodule

bind per_flow_seq_regression_counter pfsrc_checker u_pfsrc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .protocol    (protocol),
    .done        (done),
    .regressions (regressions),
    .new_flow    (new_flow),
    .table_full  (table_full),
    .ignored     (ignored)
);

// ===== sim/tb_per_flow_seq_regression_counter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_per_flow_seq_regression_counter
// Drives packet header transactions into the flow counter. A local copy of
// the flow table predicts each result: lookup, allocation, table full,
// non-TCP pass-through and saturating sequence regression counts. Every
// result strobe is checked field by field against the oldest prediction.
// Stimulus is a directed set of key and sequence corner cases, then random
// traffic over a growing pool of flows that overflows the table.
// ----------------------------------------------------------------------------
module tb_per_flow_seq_regression_counter;

    localparam int RANDOM_PACKETS = 450;

    typedef struct {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
        logic [31:0] seq_number;
        int unsigned gap;
    } packet_t;

    typedef struct {
        logic [31:0] regressions;
        logic        new_flow;
        logic        table_full;
        logic        ignored;
    } flow_result_t;

    typedef struct {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] last_seq;
    } flow_key_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        start      = 1'b0;
    logic [31:0] src_addr   = '0;
    logic [31:0] dst_addr   = '0;
    logic [15:0] src_port   = '0;
    logic [15:0] dst_port   = '0;
    logic [7:0]  protocol   = '0;
    logic [31:0] seq_number = '0;
    logic        busy;
    logic        done;
    logic [31:0] regressions;
    logic        new_flow;
    logic        table_full;
    logic        ignored;

    packet_t      packet_q[$];
    flow_result_t flow_results_q[$];
    flow_key_t    flow_pool[$];
    int unsigned  mismatch_cnt = 0;
    int unsigned  idle_cnt = 0;
    int unsigned  burst_left = 0;

    // Predicted flow table
    bit          tbl_valid[pfsrc_pkg::FLOW_ENTRIES_DEF];
    logic [63:0] tbl_addrs[pfsrc_pkg::FLOW_ENTRIES_DEF];
    logic [31:0] tbl_ports[pfsrc_pkg::FLOW_ENTRIES_DEF];
    logic [31:0] tbl_last_seq[pfsrc_pkg::FLOW_ENTRIES_DEF];
    logic [31:0] tbl_count[pfsrc_pkg::FLOW_ENTRIES_DEF];
    int unsigned tbl_next_free = 0;

    per_flow_seq_regression_counter #(
        .FLOW_ENTRIES (pfsrc_pkg::FLOW_ENTRIES_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .src_addr    (src_addr),
        .dst_addr    (dst_addr),
        .src_port    (src_port),
        .dst_port    (dst_port),
        .protocol    (protocol),
        .seq_number  (seq_number),
        .done        (done),
        .regressions (regressions),
        .new_flow    (new_flow),
        .table_full  (table_full),
        .ignored     (ignored)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic flow_result_t flow_table_lookup(
        logic [31:0] sa, logic [31:0] da, logic [15:0] sp, logic [15:0] dp,
        logic [7:0] proto, logic [31:0] seq);
        flow_result_t res;
        logic [63:0]  addrs;
        logic [31:0]  ports;
        int           slot;
        res   = '{regressions: '0, new_flow: 1'b0, table_full: 1'b0, ignored: 1'b0};
        addrs = {sa, da};
        ports = {sp, dp};
        slot  = -1;
        if (proto != pfsrc_pkg::TCP_PROTO)
        begin
            res.ignored = 1'b1;
            return res;
        end
        for (int i = 0; i < pfsrc_pkg::FLOW_ENTRIES_DEF; i++)
        begin
            if (slot < 0 && tbl_valid[i] && tbl_addrs[i] == addrs && tbl_ports[i] == ports)
                slot = i;
        end
        if (slot >= 0)
        begin
            if (tbl_last_seq[slot] > seq && tbl_count[slot] != pfsrc_pkg::COUNT_MAX)
                tbl_count[slot] = tbl_count[slot] + 1;
            tbl_last_seq[slot] = seq;
            res.regressions = tbl_count[slot];
        end
        else if (tbl_next_free < pfsrc_pkg::FLOW_ENTRIES_DEF)
        begin
            tbl_valid[tbl_next_free]    = 1'b1;
            tbl_addrs[tbl_next_free]    = addrs;
            tbl_ports[tbl_next_free]    = ports;
            tbl_last_seq[tbl_next_free] = seq;
            tbl_count[tbl_next_free]    = '0;
            tbl_next_free++;
            res.new_flow = 1'b1;
        end
        else
            res.table_full = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Sender gap: runs of back-to-back transactions mixed with random idles
    task automatic queue_packet(input flow_key_t key, input logic [7:0] proto,
                                input logic [31:0] seq);
        packet_t pkt;
        pkt.src_addr   = key.src_addr;
        pkt.dst_addr   = key.dst_addr;
        pkt.src_port   = key.src_port;
        pkt.dst_port   = key.dst_port;
        pkt.protocol   = proto;
        pkt.seq_number = seq;
        if (burst_left != 0)
        begin
            pkt.gap = 0;
            burst_left--;
        end
        else if ($urandom_range(0, 15) == 0)
        begin
            pkt.gap    = 0;
            burst_left = $urandom_range(5, 30);
        end
        else
            pkt.gap = $urandom_range(0, 19);
        packet_q.push_back(pkt);
    endtask

    function automatic logic [7:0] other_protocol();
        logic [7:0] p;
        p = 8'($urandom_range(0, 255));
        while (p == pfsrc_pkg::TCP_PROTO)
            p = 8'($urandom_range(0, 255));
        return p;
    endfunction

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            src_addr   <= '0;
            dst_addr   <= '0;
            src_port   <= '0;
            dst_port   <= '0;
            protocol   <= '0;
            seq_number <= '0;
            idle_cnt   <= 0;
        end
        else
        begin : drive
            logic    slot_free;
            packet_t pkt;
            slot_free = !start;
            if (start && !busy)
            begin
                flow_results_q.push_back(flow_table_lookup(src_addr, dst_addr,
                    src_port, dst_port, protocol, seq_number));
                slot_free = 1'b1;
            end
            if (slot_free)
            begin
                if (packet_q.size() != 0 && idle_cnt >= packet_q[0].gap)
                begin
                    pkt = packet_q.pop_front();
                    src_addr   <= pkt.src_addr;
                    dst_addr   <= pkt.dst_addr;
                    src_port   <= pkt.src_port;
                    dst_port   <= pkt.dst_port;
                    protocol   <= pkt.protocol;
                    seq_number <= pkt.seq_number;
                    start      <= 1'b1;
                    idle_cnt   <= 0;
                end
                else
                begin
                    start    <= 1'b0;
                    idle_cnt <= idle_cnt + 1;
                end
            end
        end
    end

    // Monitor
    always @(posedge clk)
    begin : monitor
        flow_result_t exp_res;
        if (rst_n && done === 1'b1)
        begin
            if (flow_results_q.size() == 0)
                report_mismatch($sformatf("unexpected result regressions=%0d", regressions));
            else
            begin
                exp_res = flow_results_q.pop_front();
                if (regressions !== exp_res.regressions)
                    report_mismatch($sformatf("regressions got %0d exp %0d",
                        regressions, exp_res.regressions));
                if (new_flow !== exp_res.new_flow)
                    report_mismatch($sformatf("new_flow got %b exp %b",
                        new_flow, exp_res.new_flow));
                if (table_full !== exp_res.table_full)
                    report_mismatch($sformatf("table_full got %b exp %b",
                        table_full, exp_res.table_full));
                if (ignored !== exp_res.ignored)
                    report_mismatch($sformatf("ignored got %b exp %b",
                        ignored, exp_res.ignored));
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        flow_key_t   ka, kb, kc, kd, key;
        int          idx;
        int unsigned r;
        int unsigned d;
        logic [31:0] seq;

        ka = '{src_addr: '0, dst_addr: '0, src_port: '0, dst_port: '0, last_seq: '0};
        kb = '{src_addr: '1, dst_addr: '1, src_port: '1, dst_port: '1, last_seq: '1};
        kc = ka;
        kc.src_port = 16'd1;
        kd = kb;
        kd.src_port = '0;
        kd.dst_port = '0;

        // Directed: key extremes, equal/up/down sequence, non-TCP, near-miss keys
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'hFFFF_FFFF);
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO, 32'hFFFF_FFFF);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO, 32'hFFFF_FFFE);
        queue_packet(kb, 8'd0, 32'h0000_0000);
        queue_packet(kb, 8'hFF, 32'h0000_0000);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO + 8'd1, 32'h0000_0000);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO - 8'd1, 32'h0000_0000);
        queue_packet(kc, pfsrc_pkg::TCP_PROTO, 32'h8000_0000);
        queue_packet(kd, pfsrc_pkg::TCP_PROTO, 32'h7FFF_FFFF);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO, 32'h0000_0001);
        queue_packet(kb, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        queue_packet(kc, pfsrc_pkg::TCP_PROTO, 32'h7FFF_FFFF);
        queue_packet(kd, pfsrc_pkg::TCP_PROTO, 32'h8000_0000);
        queue_packet(ka, pfsrc_pkg::TCP_PROTO, 32'h0000_0000);
        ka.last_seq = 32'h0000_0000;
        kb.last_seq = 32'h0000_0000;
        kc.last_seq = 32'h7FFF_FFFF;
        kd.last_seq = 32'h8000_0000;
        flow_pool.push_back(ka);
        flow_pool.push_back(kb);
        flow_pool.push_back(kc);
        flow_pool.push_back(kd);

        // Random traffic; the pool grows past the table size
        for (int n = 0; n < RANDOM_PACKETS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                if ($urandom_range(0, 1) == 0)
                    key = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                else
                    key = '{src_addr: $urandom, dst_addr: $urandom,
                            src_port: 16'($urandom), dst_port: 16'($urandom), last_seq: '0};
                queue_packet(key, other_protocol(), $urandom);
            end
            else if (r < 28)
            begin
                if ($urandom_range(0, 1) == 0)
                    key = '{src_addr: $urandom, dst_addr: $urandom,
                            src_port: 16'($urandom), dst_port: 16'($urandom), last_seq: '0};
                else
                begin
                    key = flow_pool[$urandom_range(0, flow_pool.size() - 1)];
                    case ($urandom_range(0, 4))
                        0: key.src_addr = $urandom;
                        1: key.dst_addr = $urandom;
                        2: key.src_port = 16'($urandom);
                        3: key.dst_port = 16'($urandom);
                        default:
                        begin
                            key.src_addr = key.dst_addr ^ 32'h1;
                            key.src_port = ~key.dst_port;
                        end
                    endcase
                end
                key.last_seq = $urandom;
                queue_packet(key, pfsrc_pkg::TCP_PROTO, key.last_seq);
                flow_pool.push_back(key);
            end
            else
            begin
                idx = $urandom_range(0, flow_pool.size() - 1);
                d   = $urandom_range(1, 2000);
                r   = $urandom_range(0, 99);
                if (r < 40)
                    seq = flow_pool[idx].last_seq + d;
                else if (r < 70)
                    seq = flow_pool[idx].last_seq - d;
                else if (r < 80)
                    seq = flow_pool[idx].last_seq;
                else if (r < 90)
                    seq = $urandom;
                else if (r < 95)
                    seq = '0;
                else
                    seq = '1;
                flow_pool[idx].last_seq = seq;
                queue_packet(flow_pool[idx], pfsrc_pkg::TCP_PROTO, seq);
            end
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (packet_q.size() != 0 || start)
            @(posedge clk);
        while (flow_results_q.size() != 0)
            @(posedge clk);
        repeat (pfsrc_pkg::LATENCY + 8) @(posedge clk);

        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== per_flow_seq_regression_counter.f =====
+incdir+sv
sv/pfsrc_pkg.sv
sv/per_flow_seq_regression_counter.sv
sv/pfsrc_checker.sv
sim/tb_per_flow_seq_regression_counter.sv
